// File: design/fsw_pkg.sv
package fsw_pkg;

    // field widths fixed by the sample and event formats
    localparam int unsigned FrameWidth   = 32;
    localparam int unsigned CountWidth   = 31;
    localparam int unsigned TimeWidth    = 40;
    localparam int unsigned ThreshWidth  = 32;

    // threshold after reset, in milliseconds
    localparam logic [ThreshWidth-1:0] ThreshReset = 32'd5000;

    // event kinds carried in the resumed field
    localparam logic EvStalled = 1'b0;
    localparam logic EvResumed = 1'b1;

    // one event as it leaves the decision logic
    typedef struct packed {
        logic                  resumed;
        logic [CountWidth-1:0] event_frame;
        logic [TimeWidth-1:0]  elapsed_ms;
    } result_t;

    // handshake between decision stage and result register
    typedef struct packed {
        logic    valid;
        result_t data;
    } result_req_t;

endpackage

// File: design/frame_stall_watchdog.sv
// channel   | direction | handshake           | payload
// sample    | in        | in_valid / in_stall  | frame_number, now_ms
// event     | out       | out_valid / out_stall| resumed, event_frame, elapsed_ms
// threshold | in        | cfg_write_en         | cfg_write_data
//
// one sample per cycle unless stalled; an event is registered after its sample is taken
// the sample register and the per-sample state update set that rate
// rst_n clears the handshake state and restores the 5000 ms threshold
// a stalled event register holds in_stall high only while a sample waits behind it
module frame_stall_watchdog (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [fsw_pkg::FrameWidth-1:0] frame_number,
    input  logic        [fsw_pkg::TimeWidth-1:0]  now_ms,
    input  logic                                  cfg_write_en,
    input  logic        [fsw_pkg::ThreshWidth-1:0] cfg_write_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  resumed,
    output logic        [fsw_pkg::CountWidth-1:0] event_frame,
    output logic        [fsw_pkg::TimeWidth-1:0]  elapsed_ms
);

    fsw_pkg::result_req_t res;
    logic                 out_free;

    // sample register, watchdog state and event decision
    fsw_eval u_eval (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_number   (frame_number),
        .now_ms         (now_ms),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_free       (out_free),
        .res            (res)
    );

    // event register toward the consumer
    fsw_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .resumed     (resumed),
        .event_frame (event_frame),
        .elapsed_ms  (elapsed_ms)
    );

endmodule

// File: design/fsw_eval.sv
module fsw_eval (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [fsw_pkg::FrameWidth-1:0] frame_number,
    input  logic        [fsw_pkg::TimeWidth-1:0]  now_ms,
    input  logic                                 cfg_write_en,
    input  logic        [fsw_pkg::ThreshWidth-1:0] cfg_write_data,
    input  logic                                 out_free,
    output fsw_pkg::result_req_t                 res
);

    // sample register
    logic                               item_valid_reg;
    logic                               item_valid_next;
    logic [fsw_pkg::FrameWidth-1:0]     item_frame_reg;
    logic [fsw_pkg::TimeWidth-1:0]      item_now_reg;

    // watchdog state
    logic [fsw_pkg::ThreshWidth-1:0]    thresh_reg;
    logic                               armed_reg;
    logic                               armed_next;
    logic [fsw_pkg::CountWidth-1:0]     last_frame_reg;
    logic [fsw_pkg::CountWidth-1:0]     last_frame_next;
    logic [fsw_pkg::TimeWidth-1:0]      last_advance_reg;
    logic [fsw_pkg::TimeWidth-1:0]      last_advance_next;
    logic                               stalled_reg;
    logic                               stalled_next;

    logic                               consume;
    logic                               load;
    logic [fsw_pkg::CountWidth-1:0]     frame;
    logic [fsw_pkg::TimeWidth-1:0]      elapsed;
    logic                               over_thresh;

    // sample moves on whenever the result register can take an event
    assign consume  = item_valid_reg && out_free;
    assign in_stall = item_valid_reg && !out_free;
    assign load     = in_valid && !in_stall;

    assign item_valid_next = load ? 1'b1 : (consume ? 1'b0 : item_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_frame_reg <= frame_number;
            item_now_reg   <= now_ms;
        end
    end

    // age of the current frame, wraps modulo 2^40
    assign frame       = item_frame_reg[fsw_pkg::CountWidth-1:0];
    assign elapsed     = item_now_reg - last_advance_reg;
    assign over_thresh = elapsed >= {{(fsw_pkg::TimeWidth-fsw_pkg::ThreshWidth){1'b0}}, thresh_reg};

    // decision and state update for one sample
    always_comb
    begin
        armed_next        = armed_reg;
        last_frame_next   = last_frame_reg;
        last_advance_next = last_advance_reg;
        stalled_next      = stalled_reg;
        res.valid            = 1'b0;
        res.data.resumed     = fsw_pkg::EvStalled;
        res.data.event_frame = frame;
        res.data.elapsed_ms  = elapsed;
        if (consume)
        begin
            if (item_frame_reg[fsw_pkg::FrameWidth-1])
            begin
                // negative frame disarms
                armed_next   = 1'b0;
                stalled_next = 1'b0;
            end
            else if (!armed_reg)
            begin
                armed_next        = 1'b1;
                last_frame_next   = frame;
                last_advance_next = item_now_reg;
            end
            else if (frame != last_frame_reg)
            begin
                last_frame_next   = frame;
                last_advance_next = item_now_reg;
                stalled_next      = 1'b0;
                res.valid         = stalled_reg;
                res.data.resumed  = fsw_pkg::EvResumed;
            end
            else if (!stalled_reg && over_thresh)
            begin
                stalled_next     = 1'b1;
                res.valid        = 1'b1;
                res.data.resumed = fsw_pkg::EvStalled;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg       <= fsw_pkg::ThreshReset;
            armed_reg        <= 1'b0;
            last_frame_reg   <= '0;
            last_advance_reg <= '0;
            stalled_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                thresh_reg <= cfg_write_data;
            end
            armed_reg        <= armed_next;
            last_frame_reg   <= last_frame_next;
            last_advance_reg <= last_advance_next;
            stalled_reg      <= stalled_next;
        end
    end

endmodule

// File: design/fsw_out.sv
module fsw_out (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fsw_pkg::result_req_t            res,
    output logic                            out_free,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            resumed,
    output logic [fsw_pkg::CountWidth-1:0]  event_frame,
    output logic [fsw_pkg::TimeWidth-1:0]   elapsed_ms
);

    logic             out_valid_reg;
    logic             out_valid_next;
    fsw_pkg::result_t out_data_reg;

    // slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid_next = res.valid ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // event payload, loaded only into a free slot
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_data_reg <= res.data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign resumed     = out_data_reg.resumed;
    assign event_frame = out_data_reg.event_frame;
    assign elapsed_ms  = out_data_reg.elapsed_ms;

endmodule

// File: design/fsw_checker.sv
module fsw_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic signed [fsw_pkg::FrameWidth-1:0] frame_number,
    input logic        [fsw_pkg::TimeWidth-1:0]  now_ms,
    input logic                                  cfg_write_en,
    input logic        [fsw_pkg::ThreshWidth-1:0] cfg_write_data,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic                                  resumed,
    input logic        [fsw_pkg::CountWidth-1:0] event_frame,
    input logic        [fsw_pkg::TimeWidth-1:0]  elapsed_ms
);

    logic [fsw_pkg::ThreshWidth-1:0] thresh_reg;
    logic                            last_stall_reg;

    // shadow of the threshold and of the kind of the last delivered event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg     <= fsw_pkg::ThreshReset;
            last_stall_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                thresh_reg <= cfg_write_data;
            end
            if (out_valid && !out_stall)
            begin
                last_stall_reg <= (resumed == fsw_pkg::EvStalled);
            end
        end
    end

    // a stalled sample request holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(frame_number) && $stable(now_ms))
        else $error("sample changed while stalled");

    // a stalled event request holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(resumed)
            && $stable(event_frame) && $stable(elapsed_ms))
        else $error("event changed while stalled");

    // samples back up only behind a blocked event
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("sample stalled with event side free");

    // a stall is reported only once the age reaches the threshold
    a_stall_age: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (resumed == fsw_pkg::EvStalled) |->
            elapsed_ms >= {{(fsw_pkg::TimeWidth-fsw_pkg::ThreshWidth){1'b0}}, thresh_reg})
        else $error("stall reported below threshold");

    // every resume follows a delivered stall
    a_resume_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (resumed == fsw_pkg::EvResumed) |-> last_stall_reg)
        else $error("resume without prior stall");

endmodule

bind frame_stall_watchdog fsw_checker u_fsw_checker (.*);

// File: sim/tb_top.sv
module tb_top;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned IdlePct    = 34;
    localparam int unsigned DrainWait  = 6;
    localparam int unsigned RandPhase  = 160;

    typedef struct packed {
        logic signed [fsw_pkg::FrameWidth-1:0] frame;
        logic        [fsw_pkg::TimeWidth-1:0]  now;
    } sample_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic signed [fsw_pkg::FrameWidth-1:0]  frame_number = '0;
    logic        [fsw_pkg::TimeWidth-1:0]   now_ms = '0;
    logic                                   cfg_write_en = 1'b0;
    logic        [fsw_pkg::ThreshWidth-1:0] cfg_write_data = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic                                   resumed;
    logic        [fsw_pkg::CountWidth-1:0]  event_frame;
    logic        [fsw_pkg::TimeWidth-1:0]   elapsed_ms;

    // requests waiting to be driven and events waiting to be seen
    sample_t          sample_q[$];
    fsw_pkg::result_t pending_events[$];
    sample_t          issued;
    int unsigned loaded_count = 0;
    int unsigned accepted_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // watchdog state as the block should hold it
    logic                            wd_armed = 1'b0;
    logic [fsw_pkg::CountWidth-1:0]  wd_last_frame = '0;
    logic [fsw_pkg::TimeWidth-1:0]   wd_last_advance = '0;
    logic                            wd_stalled = 1'b0;
    logic [fsw_pkg::ThreshWidth-1:0] wd_threshold = fsw_pkg::ThreshReset;

    // sample generator state
    logic [fsw_pkg::CountWidth-1:0]  gen_frame;
    logic [fsw_pkg::TimeWidth-1:0]   gen_now;

    // no idling on either side over a stretch of the run
    wire quiet = accepted_count >= 300 && accepted_count < 450;

    frame_stall_watchdog u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_number   (frame_number),
        .now_ms         (now_ms),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .resumed        (resumed),
        .event_frame    (event_frame),
        .elapsed_ms     (elapsed_ms)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // advance the watchdog state for one accepted sample, queue any event
    function automatic void track_sample(
        input logic signed [fsw_pkg::FrameWidth-1:0] frame,
        input logic [fsw_pkg::TimeWidth-1:0] now);
        logic [fsw_pkg::CountWidth-1:0] count;
        logic [fsw_pkg::TimeWidth-1:0]  age;
        fsw_pkg::result_t               ev;
        count = frame[fsw_pkg::CountWidth-1:0];
        age = now - wd_last_advance;
        ev.event_frame = count;
        ev.elapsed_ms = age;
        if (frame[fsw_pkg::FrameWidth-1])
        begin
            wd_armed = 1'b0;
            wd_stalled = 1'b0;
        end
        else if (!wd_armed)
        begin
            wd_armed = 1'b1;
            wd_last_frame = count;
            wd_last_advance = now;
        end
        else if (count != wd_last_frame)
        begin
            if (wd_stalled)
            begin
                ev.resumed = fsw_pkg::EvResumed;
                pending_events.push_back(ev);
            end
            wd_last_frame = count;
            wd_last_advance = now;
            wd_stalled = 1'b0;
        end
        else if (!wd_stalled && age >= {8'd0, wd_threshold})
        begin
            wd_stalled = 1'b1;
            ev.resumed = fsw_pkg::EvStalled;
            pending_events.push_back(ev);
        end
    endfunction

    task automatic queue_sample(input logic signed [fsw_pkg::FrameWidth-1:0] frame,
                                input logic [fsw_pkg::TimeWidth-1:0] now);
        sample_q.push_back({frame, now});
        loaded_count++;
    endtask

    // sequences that stall and resume around the threshold, with disarms and jumps
    task automatic queue_random_samples(input int unsigned count,
                                        input logic [fsw_pkg::ThreshWidth-1:0] thr);
        logic [fsw_pkg::TimeWidth-1:0] step;
        logic [fsw_pkg::TimeWidth-1:0] thr_ext;
        int unsigned                   pick;
        thr_ext = {8'd0, thr};
        for (int unsigned i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2: step = 40'($urandom_range(3));
                3, 4:    step = {8'd0, 32'($urandom)} % (thr_ext / 2 + 1);
                5, 6:    step = thr_ext - 1 + 40'($urandom_range(2));
                7:       step = thr_ext + 40'($urandom_range(1000));
                8:       step = {8'($urandom_range(255)), 32'($urandom)};
                default: step = '0;
            endcase
            gen_now = gen_now + step;
            pick = $urandom_range(99);
            if (pick < 7)
                queue_sample({1'b1, 31'($urandom)}, gen_now);
            else
            begin
                if (pick < 18)
                    gen_frame = gen_frame + 1'b1;
                else if (pick < 30)
                    gen_frame = 31'($urandom);
                queue_sample({1'b0, gen_frame}, gen_now);
            end
        end
    endtask

    // block is idle once every request is taken, every event seen and the pipe drained
    task automatic wait_idle();
        while (accepted_count != loaded_count || pending_events.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [fsw_pkg::ThreshWidth-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        wd_threshold = value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_sample(frame_number, now_ms);
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (sample_q.size() != 0 && (quiet || $urandom_range(99) >= IdlePct))
                begin
                    issued = sample_q.pop_front();
                    in_valid <= 1'b1;
                    frame_number <= issued.frame;
                    now_ms <= issued.now;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // event monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: unexpected event resumed=%0b frame=%h elapsed=%h",
                             $time, resumed, event_frame, elapsed_ms);
                    mismatch_count++;
                end
                else
                begin
                    if (resumed !== pending_events[0].resumed)
                    begin
                        $display("%0t: resumed expected %0b actual %0b",
                                 $time, pending_events[0].resumed, resumed);
                        mismatch_count++;
                    end
                    if (event_frame !== pending_events[0].event_frame)
                    begin
                        $display("%0t: event_frame expected %h actual %h",
                                 $time, pending_events[0].event_frame, event_frame);
                        mismatch_count++;
                    end
                    if (elapsed_ms !== pending_events[0].elapsed_ms)
                    begin
                        $display("%0t: elapsed_ms expected %h actual %h",
                                 $time, pending_events[0].elapsed_ms, elapsed_ms);
                        mismatch_count++;
                    end
                    void'(pending_events.pop_front());
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < IdlePct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("frame_stall_watchdog regression: fail");
            $finish;
        end
    end

    // stimulus phases, threshold changes only while idle
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // disarm at both ends of the negative range
        queue_sample(32'sh8000_0000, 40'd0);
        queue_sample(-32'sd1, 40'hFF_FFFF_FFFF);
        // arm, just below and at the threshold, then hold stalled
        queue_sample(32'sd0, 40'd0);
        queue_sample(32'sd0, 40'd4999);
        queue_sample(32'sd0, 40'd5000);
        queue_sample(32'sd0, 40'd9000);
        // resume after stall
        queue_sample(32'sd1, 40'd9001);
        // largest frame, timestamp wrapping past zero
        queue_sample(32'sh7FFF_FFFF, 40'hFF_FFFF_FFFF);
        queue_sample(32'sh7FFF_FFFF, 40'd4999);
        // timestamp going backwards after re-arm
        queue_sample(-32'sd5, 40'd100);
        queue_sample(32'sd5, 40'd100);
        queue_sample(32'sd5, 40'd50);
        queue_sample(32'sd6, 40'd60);
        // stall cleared by disarm gives no resume, then change without stall
        queue_sample(32'sd6, 40'd5059);
        queue_sample(32'sd6, 40'd5060);
        queue_sample(32'sh8000_0000, 40'd5061);
        queue_sample(32'sd6, 40'd20000);
        queue_sample(32'sd6, 40'd20001);
        queue_sample(32'sd7, 40'd30000);
        queue_sample(32'sd7, 40'd35000);
        wait_idle();

        gen_frame = 31'($urandom);
        gen_now = {8'($urandom_range(255)), 32'($urandom)};
        queue_random_samples(RandPhase, fsw_pkg::ThreshReset);
        wait_idle();

        write_threshold(32'd1);
        queue_random_samples(RandPhase, 32'd1);
        wait_idle();

        write_threshold(32'd0);
        queue_random_samples(RandPhase, 32'd0);
        wait_idle();

        write_threshold(32'hFFFF_FFFF);
        queue_random_samples(RandPhase, 32'hFFFF_FFFF);
        wait_idle();

        write_threshold(32'($urandom_range(20000, 100)));
        queue_random_samples(RandPhase, wd_threshold);
        wait_idle();

        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("frame_stall_watchdog regression: pass");
        else
            $display("frame_stall_watchdog regression: fail");
        $finish;
    end

endmodule

// File: frame_stall_watchdog.f
design/fsw_pkg.sv
design/fsw_eval.sv
design/fsw_out.sv
design/frame_stall_watchdog.sv
design/fsw_checker.sv
sim/tb_top.sv
